>>> sv/rcfr_pkg.sv
// Shared types and constants for the radio command frame receiver.
// No dependencies; the interfaces, the deframer and the top level use this package.
`default_nettype none

package rcfr_pkg;

	localparam int BODY_DEPTH   = 256;
	localparam int HEADER_BYTES = 5;
	localparam int BODY_AW      = $clog2(BODY_DEPTH);
	localparam int HPOS_W       = $clog2(HEADER_BYTES + 1);
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 8;

	localparam logic [HPOS_W-1:0] HPOS_IDLE   = HPOS_W'(0);
	localparam logic [HPOS_W-1:0] HPOS_FIRST  = HPOS_W'(1);
	localparam logic [HPOS_W-1:0] HPOS_SECOND = HPOS_W'(1);
	localparam logic [HPOS_W-1:0] HPOS_THIRD  = HPOS_W'(2);
	localparam logic [HPOS_W-1:0] HPOS_LEN    = HPOS_W'(4);
	localparam logic [HPOS_W-1:0] HPOS_FULL   = HPOS_W'(HEADER_BYTES);

	localparam logic [7:0] LEN_OVERHEAD = 8'd2;
	localparam logic [7:0] LEN_SHORT    = 8'd1;

	localparam logic OP_RX   = 1'b0;
	localparam logic OP_READ = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_SYNC_FIRST   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_SYNC_SECOND  = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_COMMAND_TYPE = CFG_IDX_W'(2);

	typedef struct packed {
		logic       opcode;
		logic [7:0] rx_byte;
		logic [7:0] read_index;
	} in_beat_t;

	typedef struct packed {
		logic       frame_done;
		logic [7:0] frame_id;
		logic [7:0] ack_number;
		logic [7:0] payload_length;
		logic       short_frame;
		logic [7:0] read_data;
	} out_beat_t;

	typedef struct packed {
		logic [7:0] sync_first;
		logic [7:0] sync_second;
		logic [7:0] command_type;
	} cfg_t;

	typedef struct packed {
		logic       frame_done;
		logic [7:0] frame_id;
		logic [7:0] ack_number;
		logic [7:0] payload_length;
		logic       short_frame;
	} frame_res_t;

	typedef struct packed {
		logic               en;
		logic [BODY_AW-1:0] addr;
		logic [7:0]         data;
	} ram_wr_t;

endpackage

`default_nettype wire

>>> sv/rcfr_if.sv
// Valid/ready channel interfaces for input and result beats.
// Depends on rcfr_pkg for the payload types.
`default_nettype none

interface rcfr_in_if;
	logic               valid;
	logic               ready;
	rcfr_pkg::in_beat_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface rcfr_out_if;
	logic                valid;
	logic                ready;
	rcfr_pkg::out_beat_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> sv/rcfr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module rcfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

>>> sv/rcfr_deframer.sv
// Header and body tracking for received bytes; one byte per step.
// Depends on rcfr_pkg; drives the body buffer write port.
`default_nettype none

module rcfr_deframer (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 step,
	input  wire logic [7:0]           rx_byte,
	input  wire rcfr_pkg::cfg_t       cfg,
	output      rcfr_pkg::frame_res_t res,
	output      rcfr_pkg::ram_wr_t    ram_wr
);
	import rcfr_pkg::*;

	logic [7:0]        hdr0_q, hdr1_q, hdr2_q, hdr4_q;
	logic [HPOS_W-1:0] hpos_q;
	logic              recv_q;
	logic [7:0]        blen_q, bpos_q, ack_q, id_q;

	logic [7:0]        hdr0_d, hdr1_d, hdr2_d, hdr4_d;
	logic [HPOS_W-1:0] hpos_d;
	logic              recv_d;
	logic [7:0]        blen_d, bpos_d, ack_d, id_d;
	logic              sync_hit, collecting, match;
	logic [7:0]        bpos_inc;

	assign sync_hit   = (rx_byte == cfg.sync_first);
	assign collecting = (hpos_q != HPOS_IDLE) && (hpos_q != HPOS_FULL);
	assign bpos_inc   = bpos_q + 8'd1;

	always_comb begin
		hdr0_d = hdr0_q;
		hdr1_d = hdr1_q;
		hdr2_d = hdr2_q;
		hdr4_d = hdr4_q;
		hpos_d = hpos_q;
		recv_d = recv_q;
		blen_d = blen_q;
		bpos_d = bpos_q;
		ack_d  = ack_q;
		id_d   = id_q;
		res    = '0;
		ram_wr = '0;
		if (collecting) begin
			if (hpos_q == HPOS_SECOND) hdr1_d = rx_byte;
			if (hpos_q == HPOS_THIRD)  hdr2_d = rx_byte;
			if (hpos_q == HPOS_LEN)    hdr4_d = rx_byte;
			hpos_d = hpos_q + HPOS_W'(1);
		end
		if (sync_hit) begin
			hdr0_d = rx_byte;
			hpos_d = HPOS_FIRST;
		end
		match = (hpos_d == HPOS_FULL) && (hdr0_d == cfg.sync_first)
			&& (hdr1_d == cfg.sync_second) && (hdr2_d == cfg.command_type);
		if (match) begin
			hpos_d = HPOS_IDLE;
			blen_d = hdr4_d;
			bpos_d = 8'd0;
			recv_d = 1'b1;
		end else if (recv_q) begin
			ram_wr.en   = 1'b1;
			ram_wr.addr = BODY_AW'(bpos_q);
			ram_wr.data = rx_byte;
			if (bpos_q == 8'd0) ack_d = rx_byte;
			if (bpos_q == 8'd1) id_d = rx_byte;
			bpos_d = bpos_inc;
			if (bpos_inc == blen_q) begin
				recv_d             = 1'b0;
				blen_d             = 8'd0;
				res.frame_done     = 1'b1;
				res.short_frame    = (blen_q == LEN_SHORT);
				res.ack_number     = ack_d;
				res.frame_id       = (blen_q == LEN_SHORT) ? 8'd0 : id_d;
				res.payload_length = (blen_q == LEN_SHORT) ? 8'd0 : blen_q - LEN_OVERHEAD;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr0_q <= '0;
			hdr1_q <= '0;
			hdr2_q <= '0;
			hdr4_q <= '0;
			hpos_q <= HPOS_IDLE;
			recv_q <= 1'b0;
			blen_q <= '0;
			bpos_q <= '0;
		end else if (step) begin
			hdr0_q <= hdr0_d;
			hdr1_q <= hdr1_d;
			hdr2_q <= hdr2_d;
			hdr4_q <= hdr4_d;
			hpos_q <= hpos_d;
			recv_q <= recv_d;
			blen_q <= blen_d;
			bpos_q <= bpos_d;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			ack_q <= ack_d;
			id_q  <= id_d;
		end
	end

endmodule

`default_nettype wire

>>> sv/radio_command_frame_receiver_unit.sv
// Top level of the radio command frame receiver: channels, config, body buffer.
// Depends on rcfr_pkg, rcfr_if, rcfr_ram and rcfr_deframer.
//
//   port          dir   beat contents
//   in_ch         sink  opcode, rx_byte, read_index
//   out_ch        src   frame_done, frame_id, ack_number, payload_length,
//                       short_frame, read_data
//   write_*       in    register index and 8-bit value, no handshake
//
// One beat in and one beat out per cycle while out_ch.ready holds; a beat passes
// the input register, then the result register alongside the body buffer's registered read.
// Reset clears all control state and the config registers to zero.
// A stalled result holds both stages; in_ch.ready drops only when both are full.
`default_nettype none

module radio_command_frame_receiver_unit (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	rcfr_in_if.sink                                 in_ch,
	rcfr_out_if.source                              out_ch,
	input  wire logic                               write_enable,
	input  wire logic [rcfr_pkg::CFG_IDX_W-1:0]     write_index,
	input  wire logic [rcfr_pkg::CFG_DATA_W-1:0]    write_data
);
	import rcfr_pkg::*;

	cfg_t       cfg_q;
	in_beat_t   item_s1;
	logic       valid_s1;
	frame_res_t res_s2;
	logic       read_s2;
	logic       valid_s2;

	logic       advance, load_s1, step, ram_re;
	frame_res_t res;
	ram_wr_t    ram_wr;
	logic [7:0] ram_rdata;

	assign advance     = !valid_s2 || out_ch.ready;
	assign in_ch.ready = !valid_s1 || advance;
	assign load_s1     = in_ch.valid && in_ch.ready;
	assign step        = valid_s1 && advance && (item_s1.opcode == OP_RX);
	assign ram_re      = valid_s1 && advance && (item_s1.opcode == OP_READ);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (write_enable) begin
			unique case (write_index)
				REG_SYNC_FIRST:   cfg_q.sync_first   <= write_data;
				REG_SYNC_SECOND:  cfg_q.sync_second  <= write_data;
				REG_COMMAND_TYPE: cfg_q.command_type <= write_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ch.ready) valid_s1 <= in_ch.valid;
			if (advance)     valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) item_s1 <= in_ch.payload;
		if (advance) begin
			res_s2  <= res;
			read_s2 <= (item_s1.opcode == OP_READ);
		end
	end

	rcfr_deframer u_deframer (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.rx_byte (item_s1.rx_byte),
		.cfg     (cfg_q),
		.res     (res),
		.ram_wr  (ram_wr)
	);

	rcfr_ram #(
		.WIDTH (8),
		.DEPTH (BODY_DEPTH)
	) u_body_ram (
		.clk   (clk),
		.we    (ram_wr.en && step),
		.waddr (ram_wr.addr),
		.wdata (ram_wr.data),
		.re    (ram_re),
		.raddr (BODY_AW'(item_s1.read_index)),
		.rdata (ram_rdata)
	);

	always_comb begin
		out_ch.valid                  = valid_s2;
		out_ch.payload.frame_done     = read_s2 ? 1'b0 : res_s2.frame_done;
		out_ch.payload.frame_id       = read_s2 ? 8'd0 : res_s2.frame_id;
		out_ch.payload.ack_number     = read_s2 ? 8'd0 : res_s2.ack_number;
		out_ch.payload.payload_length = read_s2 ? 8'd0 : res_s2.payload_length;
		out_ch.payload.short_frame    = read_s2 ? 1'b0 : res_s2.short_frame;
		out_ch.payload.read_data      = read_s2 ? ram_rdata : 8'd0;
	end

	a_no_write_on_read: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_re && ram_wr.en && step))
		else $error("body buffer written by a read beat");

	a_short_len: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.payload.short_frame) |->
			(out_ch.payload.frame_done && out_ch.payload.payload_length == 8'd0))
		else $error("short frame with non-zero payload length");

	a_s2_loads_from_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && advance) |=> valid_s2)
		else $error("result stage lost a beat");

	a_ready_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		(!valid_s1 || !valid_s2) |-> in_ch.ready)
		else $error("input stalled with a free stage");

endmodule

`default_nettype wire
